// ===== src/i2a_pkg.sv =====
// Shared types, command codes and character helpers for the integer to ASCII converter.
package i2a_pkg;

  typedef logic [1:0] cmd_t;

  localparam cmd_t CMD_UDEC = 2'd0;
  localparam cmd_t CMD_UHEX = 2'd1;
  localparam cmd_t CMD_SDEC = 2'd2;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] CHAR_ALPHA = 8'h61;  // 'a'
  localparam logic [7:0] CHAR_MINUS = 8'h2d;  // '-'

  localparam logic [3:0] RADIX_DEC = 4'd10;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIGN,
    ST_SKIP,
    ST_EMIT
  } state_t;

  // One digit (0..15) to its lowercase ASCII code.
  function automatic logic [7:0] digit_char(input logic [3:0] d);
    logic [7:0] ch;
    if (d < RADIX_DEC) begin
      ch = CHAR_ZERO + {4'b0, d};
    end else begin
      ch = CHAR_ALPHA + {4'b0, d - RADIX_DEC};
    end
    return ch;
  endfunction

endpackage

// ===== src/integer_to_ascii_digits.sv =====
// Top level: binary to ASCII decimal/hex converter with stream request ports.
// Flow, decimal modes: accept, SW shift steps in the bit-serial double-dabble unit
//   (SW = max(VALUE_WIDTH, 32)), take the BCD digits, a sign if negative, skip each
//   leading zero digit and find the first digit. Hex mode has no shift or take steps.
// Then one character per cycle while the sink keeps up.
// A new number is accepted only in idle, once the last character of the previous one
//   is loaded into the output register.
// Reset (rst, synchronous, high) returns to idle and empties the output register.
module integer_to_ascii_digits #(
  parameter int VALUE_WIDTH = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [63:0]        s_axis_tdata,   // [63:0] value
  input  i2a_pkg::cmd_t      s_axis_tuser,   // [1:0] cmd
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [7:0]         m_axis_tdata,   // [7:0] char_code
  output logic               m_axis_tlast
);
  import i2a_pkg::*;

  // Shift width covers the unsigned operand and the 32-bit signed magnitude.
  localparam int SW = (VALUE_WIDTH > 32) ? VALUE_WIDTH : 32;
  // Decimal digits for SW bits: floor(SW * log10(2)) + 1, 1233/4096 ~ log10(2).
  localparam int ND = (SW * 1233) / 4096 + 1;
  localparam int DW = ND * 4;
  localparam int RW = $clog2(ND + 1);

  state_t          state, state_next;
  logic [DW-1:0]   dig;        // digit shifter, most significant digit on top
  logic [RW-1:0]   rem;        // digits still in the shifter
  logic            neg;        // signed input was negative
  logic            accept;
  logic            out_free;
  logic            bcd_start;
  logic            bcd_busy;
  logic [DW-1:0]   bcd_digits;
  logic [SW-1:0]   conv_bits;
  logic [31:0]     low;
  logic [31:0]     mag32;
  logic [3:0]      top;

  // Strobes decoded from the state
  logic            load_hex;
  logic            take_bcd;
  logic            put_sign;
  logic            skip_zero;
  logic            put_digit;

  assign s_axis_tready = (state == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign top           = dig[DW-1 -: 4];

  // Signed mode: two's complement magnitude of the low word; 0x80000000 stays 2^31.
  assign low   = s_axis_tdata[31:0];
  assign mag32 = low[31] ? (~low + 32'd1) : low;

  always_comb begin
    if (s_axis_tuser == CMD_SDEC) begin
      conv_bits = SW'(mag32);
    end else begin
      conv_bits = SW'(s_axis_tdata[VALUE_WIDTH-1:0]);
    end
  end

  i2a_dabble #(
    .SW (SW),
    .ND (ND)
  ) u_dabble (
    .clk     (clk),
    .rst     (rst),
    .start   (bcd_start),
    .bits_in (conv_bits),
    .busy    (bcd_busy),
    .digits  (bcd_digits)
  );

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (s_axis_tuser)
            CMD_UDEC: state_next = ST_CONV;
            CMD_SDEC: state_next = ST_CONV;
            CMD_UHEX: state_next = ST_SKIP;
            default:  state_next = ST_IDLE;   // unused command: dropped
          endcase
        end
      end
      ST_CONV: begin
        if (!bcd_busy) begin
          state_next = neg ? ST_SIGN : ST_SKIP;
        end
      end
      ST_SIGN: begin
        if (out_free) begin
          state_next = ST_SKIP;
        end
      end
      ST_SKIP: begin
        if (top != 4'd0 || rem == RW'(1)) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free && rem == RW'(1)) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Datapath strobes
  always_comb begin
    bcd_start = 1'b0;
    load_hex  = 1'b0;
    take_bcd  = 1'b0;
    put_sign  = 1'b0;
    skip_zero = 1'b0;
    put_digit = 1'b0;
    case (state)
      ST_IDLE: begin
        bcd_start = accept && (s_axis_tuser == CMD_UDEC || s_axis_tuser == CMD_SDEC);
        load_hex  = accept && (s_axis_tuser == CMD_UHEX);
      end
      ST_CONV: take_bcd  = !bcd_busy;
      ST_SIGN: put_sign  = out_free;
      ST_SKIP: skip_zero = (top == 4'd0) && (rem != RW'(1));
      ST_EMIT: put_digit = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (bcd_start || load_hex) begin
      neg <= (s_axis_tuser == CMD_SDEC) && low[31];
      rem <= RW'(ND);
    end else if (skip_zero || put_digit) begin
      rem <= rem - 1'b1;
    end
    if (load_hex) begin
      dig <= DW'(s_axis_tdata[VALUE_WIDTH-1:0]);
    end else if (take_bcd) begin
      dig <= bcd_digits;
    end else if (skip_zero || put_digit) begin
      dig <= {dig[DW-5:0], 4'd0};
    end
  end

  // Output register: next character loads as soon as the current one is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (put_sign || put_digit) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (put_sign) begin
      m_axis_tdata <= CHAR_MINUS;
      m_axis_tlast <= 1'b0;
    end else if (put_digit) begin
      m_axis_tdata <= digit_char(top);
      m_axis_tlast <= (rem == RW'(1));
    end
  end

  // The converter only runs while a decimal request is in conversion.
  a_idle_not_busy : assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !bcd_busy)
    else $error("bcd unit busy while idle");

  // A sign is only written for a negative signed request.
  a_sign_neg : assert property (@(posedge clk) disable iff (rst)
    (state == ST_SIGN) |-> neg)
    else $error("sign state without negative value");

  // The digit shifter never runs dry before the final character.
  a_rem_nonzero : assert property (@(posedge clk) disable iff (rst)
    (state == ST_SKIP || state == ST_EMIT) |-> (rem != '0))
    else $error("digit count empty while emitting");

  // A character put out is held valid in the next cycle.
  a_emit_valid : assert property (@(posedge clk) disable iff (rst)
    (put_sign || put_digit) |=> m_axis_tvalid)
    else $error("character lost at output register");

endmodule

// ===== src/i2a_dabble.sv =====
// Bit-serial binary to BCD converter (shift and add three), one input bit per cycle.
module i2a_dabble #(
  parameter int SW = 64,
  parameter int ND = 20
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [SW-1:0]     bits_in,
  output logic              busy,
  output logic [ND*4-1:0]   digits
);
  import i2a_pkg::*;

  localparam int DW = ND * 4;
  localparam int CW = $clog2(SW + 1);

  logic [SW-1:0] sreg;
  logic [DW-1:0] bcd;
  logic [DW-1:0] adj;
  logic [CW-1:0] cnt;

  // Correct every digit that would pass nine after the doubling.
  always_comb begin
    for (int i = 0; i < ND; i++) begin
      adj[i*4 +: 4] = (bcd[i*4 +: 4] >= 4'd5) ? bcd[i*4 +: 4] + 4'd3 : bcd[i*4 +: 4];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CW'(SW);
    end else if (cnt != '0) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sreg <= bits_in;
      bcd  <= '0;
    end else if (cnt != '0) begin
      bcd  <= {adj[DW-2:0], sreg[SW-1]};
      sreg <= {sreg[SW-2:0], 1'b0};
    end
  end

  assign busy   = (cnt != '0);
  assign digits = bcd;

endmodule

// ===== dv/integer_to_ascii_digits_test.sv =====
// Self-checking stream testbench for the integer to ASCII digit converter.
module integer_to_ascii_digits_test;
  import i2a_pkg::*;

  localparam int VALUE_WIDTH = 64;
  localparam logic [63:0] WIDTH_MASK = {64{1'b1}} >> (64 - VALUE_WIDTH);
  // Command code 3 has no conversion: the block drops such a request.
  localparam cmd_t CMD_UNUSED = 2'd3;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 200;

  typedef struct {
    cmd_t        cmd;
    logic [63:0] value;
  } number_req_t;

  typedef struct {
    logic [7:0] code;
    logic       last;
  } text_char_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;   // [63:0] value
  cmd_t        s_axis_tuser = CMD_UDEC;  // [1:0] cmd
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;        // [7:0] char_code
  logic        m_axis_tlast;

  number_req_t number_queue[$];   // requests not yet offered
  text_char_t  text_fifo[$];      // characters still owed by the block
  int          err_count = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  logic        in_taken = 1'b0;
  logic        hold_go = 1'b0;
  logic        hold_active = 1'b0;
  logic        hold_done = 1'b0;
  text_char_t  want;

  integer_to_ascii_digits #(.VALUE_WIDTH(VALUE_WIDTH)) dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk = ~clk;

  // Expand one request into the characters the block must emit, MSD first.
  task automatic predict_text(input cmd_t cmd, input logic [63:0] value);
    logic [63:0] mag;
    logic [63:0] radix;
    logic [63:0] d;
    logic [31:0] low;
    logic        negative;
    logic [7:0]  digs [0:23];
    int          nd;
    text_char_t  ch;
    negative = 1'b0;
    nd = 0;
    case (cmd)
      CMD_UDEC: begin
        radix = 64'd10;
        mag = value & WIDTH_MASK;
      end
      CMD_UHEX: begin
        radix = 64'd16;
        mag = value & WIDTH_MASK;
      end
      CMD_SDEC: begin
        radix = 64'd10;
        low = value[31:0];
        negative = low[31];
        // 32-bit negate; the most negative value comes out as 2^31, its true magnitude
        if (negative) low = ~low + 32'd1;
        mag = {32'b0, low};
      end
      default: return;  // unused command: nothing comes out
    endcase
    // do-while so that zero still yields a single '0'
    do begin
      d = mag % radix;
      digs[nd] = (d < 64'd10) ? CHAR_ZERO + d[7:0] : CHAR_ALPHA + (d[7:0] - 8'd10);
      nd++;
      mag = mag / radix;
    end while (mag != 64'd0);
    if (negative) begin
      ch.code = CHAR_MINUS;
      ch.last = 1'b0;
      text_fifo.push_back(ch);
    end
    for (int i = nd - 1; i >= 0; i--) begin
      ch.code = digs[i];
      ch.last = (i == 0);
      text_fifo.push_back(ch);
    end
  endtask

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] exp);
    if (err_count < 50)
      $display("MISMATCH %s: got %h expected %h at %0t", what, got, exp, $realtime);
    err_count++;
  endtask

  task automatic push_number(input cmd_t cmd, input logic [63:0] value);
    number_req_t req;
    req.cmd = cmd;
    req.value = value;
    number_queue.push_back(req);
  endtask

  // Random requests; digit counts spread by shifting, plus values with a zero low half,
  // all ones and powers of ten (and one below) to hit every carry boundary.
  task automatic queue_random(input int count);
    logic [63:0] raw;
    logic [63:0] tens;
    logic [63:0] value;
    logic [31:0] low;
    cmd_t        cmd;
    int          pick;
    int          sel;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      cmd = (pick < 33) ? CMD_UDEC : (pick < 63) ? CMD_UHEX :
            (pick < 95) ? CMD_SDEC : CMD_UNUSED;
      raw = {$urandom(), $urandom()};
      sel = $urandom_range(9);
      case (sel)
        0: value = {raw[63:32], 32'b0};
        1: value = '1;
        2: begin
          tens = 64'd1;
          repeat ($urandom_range(19)) tens = tens * 64'd10;
          value = tens - $urandom_range(1);
        end
        default: value = raw >> $urandom_range(63);
      endcase
      // signed mode: short and long magnitudes of both signs, junk in the upper half
      if (cmd == CMD_SDEC && sel > 2) begin
        low = raw[31:0] >> $urandom_range(31);
        if ($urandom_range(1) == 1) low = ~low + 32'd1;
        value = {raw[63:32], low};
      end
      push_number(cmd, value);
    end
  endtask

  // Sender and receiver quiet and nothing owed.
  task automatic wait_drained;
    while (number_queue.size() != 0 || s_axis_tvalid || text_fifo.size() != 0)
      @(negedge clk);
  endtask

  task automatic run_phase(input int send_pct, input int stall_pct, input int count);
    send_idle_pct = send_pct;
    recv_stall_pct = stall_pct;
    queue_random(count);
    wait_drained();
  endtask

  // Request driver: new item only once the previous one was taken.
  always @(negedge clk) begin
    number_req_t req;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || in_taken) begin
      if (number_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        req = number_queue.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= req.value;
        s_axis_tuser <= req.cmd;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Sink ready: random stalls, forced low during the long hold-off.
  always @(negedge clk) begin
    if (rst || hold_active) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: predict on each accepted request, check each accepted character.
  always @(posedge clk) begin
    in_taken <= !rst && s_axis_tvalid && s_axis_tready;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) predict_text(s_axis_tuser, s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) begin
        if (text_fifo.size() == 0) begin
          report_mismatch("unexpected char", m_axis_tdata, 8'h00);
        end else begin
          want = text_fifo.pop_front();
          if (m_axis_tdata !== want.code)
            report_mismatch("char_code", m_axis_tdata, want.code);
          if (m_axis_tlast !== want.last)
            report_mismatch("last", {7'b0, m_axis_tlast}, {7'b0, want.last});
        end
      end
    end
  end

  // Long receiver hold-off, counted here so the sender keeps pushing meanwhile.
  initial begin
    wait (hold_go);
    @(negedge clk);
    hold_active <= 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk);
    hold_active <= 1'b0;
    hold_done <= 1'b1;
  end

  initial begin
    #5_000_000;
    $display("integer_to_ascii_digits verification failed");
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: extremes of each mode, zero, sign cases, unused command.
    push_number(CMD_UDEC, 64'd0);
    push_number(CMD_UDEC, 64'd1);
    push_number(CMD_UDEC, 64'd9);
    push_number(CMD_UDEC, 64'd10);
    push_number(CMD_UDEC, 64'd10000000000000000000);
    push_number(CMD_UDEC, 64'hffff_ffff_ffff_ffff);
    push_number(CMD_UHEX, 64'd0);
    push_number(CMD_UHEX, 64'h0123_4567_89ab_cdef);
    push_number(CMD_UHEX, 64'h8000_0000_0000_0000);
    push_number(CMD_UHEX, 64'hffff_ffff_ffff_ffff);
    push_number(CMD_SDEC, 64'd0);
    push_number(CMD_SDEC, 64'h0000_0000_7fff_ffff);
    push_number(CMD_SDEC, 64'h0000_0000_8000_0000);  // most negative
    push_number(CMD_SDEC, 64'h1234_5678_8000_0000);  // most negative, upper junk
    push_number(CMD_SDEC, 64'hffff_ffff_ffff_ffff);  // -1
    push_number(CMD_SDEC, 64'hdead_beef_0000_0005);  // upper bits ignored
    push_number(CMD_SDEC, 64'hffff_ffff_0000_0000);  // zero under upper junk
    push_number(CMD_UNUSED, 64'd12345);
    push_number(CMD_UNUSED, 64'hffff_ffff_ffff_ffff);
    push_number(CMD_UDEC, 64'd42);
    wait_drained();

    // Random phases: free flow, idle sender, stalling sink, both.
    run_phase(0, 0, 75);
    run_phase(74, 0, 75);
    run_phase(0, 74, 75);
    run_phase(38, 38, 75);

    // Backpressure: sink held off while the sender keeps offering.
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_go = 1'b1;
    queue_random(30);
    wait (hold_done);
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("integer_to_ascii_digits verification clean");
    end else begin
      $display("integer_to_ascii_digits verification failed");
    end
    $finish;
  end

endmodule
